// ----- rtl/mjdcal_pkg.sv -----
// Package for the MJD and BCD time to calendar converter.
// Holds the shared result types, the fixed-point constants and the BCD helper.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package mjdcal_pkg;

    // Number of register stages from request acceptance to result.
    localparam int unsigned DEPTH = 6;

    // First day on or after 1900-03-01.
    localparam logic [15:0] MJD_FIRST_VALID = 16'd15079;

    // y2 = (20*mjd - 301564) div 7305, done as a reciprocal multiply.
    localparam logic [20:0] N_OFFSET   = 21'd301564;
    localparam int unsigned Y_SHIFT    = 33;
    localparam logic [20:0] Y_RECIP    = 21'(((64'd1 << 33) + 64'd7304) / 64'd7305);

    // Whole years in days: (y2*1461) div 4.
    localparam logic [17:0] DAYS_4YR   = 18'd1461;
    localparam logic [15:0] MJD_EPOCH_DAYS = 16'd14956;

    // m2 = (10000*(mjd - 14956 - Y) - 1000) div 306001, by reciprocal multiply.
    localparam logic [22:0] M_SCALE    = 23'd10000;
    localparam logic [22:0] M_OFFSET   = 23'd1000;
    localparam int unsigned M_SHIFT    = 42;
    localparam logic [23:0] M_RECIP    = 24'(((64'd1 << 42) + 64'd306000) / 64'd306001);

    localparam logic [10:0] YEAR_BASE  = 11'd1900;
    localparam logic [3:0]  MONTH_WRAP = 4'd12;

    typedef struct packed {
        logic        valid_res;
        logic [10:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } date_t;

    typedef struct packed {
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
    } tod_t;

    // Days in the months before m2: (m2*306001) div 10000.
    function automatic logic [8:0] month_days(input logic [3:0] m2);
        logic [8:0] d;
        unique case (m2)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd30;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd91;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd183;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd244;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd336;
            4'd12:   d = 9'd367;
            4'd13:   d = 9'd397;
            4'd14:   d = 9'd428;
            4'd15:   d = 9'd459;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Tens nibble times ten plus units nibble; nibbles above nine pass unchecked.
    function automatic logic [7:0] bcd_pair(input logic [7:0] b);
        return 8'({b[7:4], 3'b000}) + 8'({b[7:4], 1'b0}) + 8'(b[3:0]);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mjd_bcd_time_to_calendar_unit.sv -----
// Converts a modified Julian date and a BCD time hhmmss into year, month, day, hour,
// minute and second. One request is taken every clock cycle while the output is not
// stalled; each result passes through the six register stages of the date path (two
// reciprocal multiplies, each with its own stage). The whole pipeline holds while a
// result waits at the output, and moves on as soon as it is taken. Dates before
// 1900-03-01 give valid_res low and a zero date; the time is decoded in every case.
// Depends on mjdcal_pkg, mjdcal_date_pipe and mjdcal_tod_pipe.
`timescale 1ns / 1ps
`default_nettype none

module mjd_bcd_time_to_calendar_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic [15:0] mjd,
    input  wire logic [23:0] bcd_time,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic        valid_res,
    output      logic [10:0] year,
    output      logic [3:0]  month,
    output      logic [4:0]  day,
    output      logic [7:0]  hour,
    output      logic [7:0]  minute,
    output      logic [7:0]  second
);
    import mjdcal_pkg::*;

    logic [DEPTH-1:0] vld_reg, vld_next;
    logic             advance;
    date_t            date;
    tod_t             tod;

    // Every stage moves together unless a finished result is still waiting.
    assign advance  = out_ready || !vld_reg[DEPTH - 1];
    assign in_ready = advance;
    assign vld_next = {vld_reg[DEPTH - 2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= vld_next;
        end
    end

    mjdcal_date_pipe u_date
    (
        .clk     (clk),
        .advance (advance),
        .mjd     (mjd),
        .date    (date)
    );

    mjdcal_tod_pipe u_tod
    (
        .clk      (clk),
        .advance  (advance),
        .bcd_time (bcd_time),
        .tod      (tod)
    );

    assign out_valid = vld_reg[DEPTH - 1];
    assign valid_res = date.valid_res;
    assign year      = date.year;
    assign month     = date.month;
    assign day       = date.day;
    assign hour      = tod.hour;
    assign minute    = tod.minute;
    assign second    = tod.second;

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> month >= 4'd1 && month <= 4'd12)
        else $error("month out of range on a valid date");

    a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> day >= 5'd1)
        else $error("day of month is zero on a valid date");

    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> year >= YEAR_BASE && year <= 11'd2039)
        else $error("year out of range on a valid date");

    a_early_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> year == '0 && month == '0 && day == '0)
        else $error("date fields not cleared for an early date");

endmodule

`default_nettype wire

// ----- rtl/mjdcal_date_pipe.sv -----
// Date datapath of the MJD converter: six register stages, two reciprocal multiplies.
// Depends on mjdcal_pkg for constants, the month table and date_t.
`timescale 1ns / 1ps
`default_nettype none

module mjdcal_date_pipe
(
    input  wire logic               clk,
    input  wire logic               advance,
    input  wire logic [15:0]        mjd,
    output mjdcal_pkg::date_t       date
);
    import mjdcal_pkg::*;

    // Stage 1
    logic [19:0] n_reg, n_next;
    logic [15:0] mjd1_reg;
    logic        ok1_reg, ok1_next;
    // Stage 2
    logic [7:0]  y2a_reg, y2a_next;
    logic [15:0] mjd2_reg;
    logic        ok2_reg;
    // Stage 3
    logic [8:0]  dd3_reg, dd3_next;
    logic [7:0]  y2b_reg;
    logic        ok3_reg;
    // Stage 4
    logic [22:0] p_reg, p_next;
    logic [8:0]  dd4_reg;
    logic [7:0]  y2c_reg;
    logic        ok4_reg;
    // Stage 5
    logic [3:0]  m2_reg, m2_next;
    logic [8:0]  dd5_reg;
    logic [7:0]  y2d_reg;
    logic        ok5_reg;
    // Stage 6
    date_t       date_reg, date_next;

    logic [20:0] n_full;
    logic [40:0] y_prod;
    logic [17:0] yd_prod;
    logic [15:0] diff_full;
    logic [46:0] m_prod;
    logic [8:0]  md;
    logic        k;

    always_comb
    begin
        ok1_next = (mjd >= MJD_FIRST_VALID);
        n_full   = 21'(mjd) * 21'd20 - N_OFFSET;
        n_next   = ok1_next ? n_full[19:0] : '0;

        y_prod   = 41'(n_reg) * 41'(Y_RECIP);
        y2a_next = y_prod[Y_SHIFT + 7:Y_SHIFT];

        yd_prod   = 18'(y2a_reg) * DAYS_4YR;
        diff_full = mjd2_reg - yd_prod[17:2] - MJD_EPOCH_DAYS;
        dd3_next  = diff_full[8:0];

        p_next = 23'(dd3_reg) * M_SCALE - M_OFFSET;

        m_prod  = 47'(p_reg) * 47'(M_RECIP);
        m2_next = m_prod[M_SHIFT + 3:M_SHIFT];

        md = month_days(m2_reg);
        // January and February count as months 14 and 15 of the previous year.
        k  = (m2_reg == 4'd14) || (m2_reg == 4'd15);
        date_next.valid_res = ok5_reg;
        date_next.year      = 11'(y2d_reg) + 11'(k) + YEAR_BASE;
        date_next.month     = m2_reg - 4'd1 - (k ? MONTH_WRAP : 4'd0);
        date_next.day       = 5'(dd5_reg - md);
        if (!ok5_reg)
        begin
            date_next.year  = '0;
            date_next.month = '0;
            date_next.day   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            n_reg    <= n_next;
            mjd1_reg <= mjd;
            ok1_reg  <= ok1_next;

            y2a_reg  <= y2a_next;
            mjd2_reg <= mjd1_reg;
            ok2_reg  <= ok1_reg;

            dd3_reg  <= dd3_next;
            y2b_reg  <= y2a_reg;
            ok3_reg  <= ok2_reg;

            p_reg    <= p_next;
            dd4_reg  <= dd3_reg;
            y2c_reg  <= y2b_reg;
            ok4_reg  <= ok3_reg;

            m2_reg   <= m2_next;
            dd5_reg  <= dd4_reg;
            y2d_reg  <= y2c_reg;
            ok5_reg  <= ok4_reg;

            date_reg <= date_next;
        end
    end

    assign date = date_reg;

endmodule

`default_nettype wire

// ----- rtl/mjdcal_tod_pipe.sv -----
// Time-of-day path: decodes the BCD digit pairs and delays them to match the date.
// Depends on mjdcal_pkg for bcd_pair, tod_t and DEPTH.
`timescale 1ns / 1ps
`default_nettype none

module mjdcal_tod_pipe
(
    input  wire logic               clk,
    input  wire logic               advance,
    input  wire logic [23:0]        bcd_time,
    output mjdcal_pkg::tod_t        tod
);
    import mjdcal_pkg::*;

    tod_t stage_reg [DEPTH];
    tod_t stage_next;

    always_comb
    begin
        stage_next.hour   = bcd_pair(bcd_time[23:16]);
        stage_next.minute = bcd_pair(bcd_time[15:8]);
        stage_next.second = bcd_pair(bcd_time[7:0]);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg[0] <= stage_next;
            for (int i = 1; i < DEPTH; i++)
            begin
                stage_reg[i] <= stage_reg[i - 1];
            end
        end
    end

    assign tod = stage_reg[DEPTH - 1];

endmodule

`default_nettype wire
